// ===== rtl/spr_pkg.sv =====
// Shared types, constants and register codes of the stream pattern replace block.
`default_nettype none

package spr_pkg;

    // Field widths fixed by the stream format.
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int COUNT_W    = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 2;

    // Default sizes of the pattern window and the replacement.
    localparam int MAX_PATTERN_DEF     = 8;
    localparam int MAX_REPLACEMENT_DEF = 8;

    // Depth of the queues on either side of the engine.
    localparam int QUEUE_DEPTH = 2;

    // A newline byte ends any chance of a match.
    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_reg;

    // Configuration register set as seen by the engine.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_bytes;
        logic [LEN_W-1:0]      pattern_length;
        logic [CFG_DATA_W-1:0] replacement_bytes;
        logic [LEN_W-1:0]      replacement_length;
    } t_cfg;

    // One input word.
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              stream_end;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               run_last;
        logic               end_of_output;
        logic [COUNT_W-1:0] replace_count;
    } t_result;

    // Queue status flags.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Engine sequencer states.
    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_REPL  = 5'b00100,
        S_FLUSH = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/spr_fifo.sv =====
// Small first-in first-out queue of flip-flops used on both sides of the engine.
`default_nettype none

module spr_fifo
    import spr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output t_qstat                o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    // Status and read side.
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spr_engine.sv =====
// Back end: scans the held window against the pattern and produces result words.
`default_nettype none

module spr_engine
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire t_qstat   i_in_stat,
    input  wire t_in_word i_in_word,
    output logic          o_in_pop,
    input  wire t_qstat   i_out_stat,
    output logic          o_res_push,
    output t_result       o_res
);

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int RW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

    t_state             r_state, n_state;
    logic [BYTE_W-1:0]  r_win [MAX_PATTERN];
    logic [BYTE_W-1:0]  n_win [MAX_PATTERN];
    logic [BYTE_W-1:0]  r_live_pat [MAX_PATTERN];
    logic [BYTE_W-1:0]  n_live_pat [MAX_PATTERN];
    logic [LEN_W-1:0]   r_live_len, n_live_len;
    logic [LEN_W-1:0]   r_n, n_n;
    logic [LEN_W-1:0]   r_ridx, n_ridx;
    logic               r_end, n_end;
    logic [COUNT_W-1:0] r_total, n_total;
    logic               r_pend_valid, n_pend_valid;
    t_result            r_pend, n_pend;

    logic [LEN_W-1:0]   cfg_pat_len;
    logic [LEN_W-1:0]   repl_len;
    logic               cfg_has_nl;
    logic [LEN_W-1:0]   cmp_len;
    logic               same;
    logic               full_hit;
    logic               pass_byte;
    logic               gen;
    logic [BYTE_W-1:0]  gen_byte;
    logic               gen_ok;
    logic               fin_push;
    logic               shift;
    t_result            fin_res;

    // Clamp the configured lengths and check the pattern for a newline.
    always_comb begin
        cfg_pat_len = (i_cfg.pattern_length > LEN_W'(MAX_PATTERN)) ?
                      LEN_W'(MAX_PATTERN) : i_cfg.pattern_length;
        repl_len    = (i_cfg.replacement_length > LEN_W'(MAX_REPLACEMENT)) ?
                      LEN_W'(MAX_REPLACEMENT) : i_cfg.replacement_length;
        cfg_has_nl  = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((LEN_W'(i) < cfg_pat_len) &&
                (i_cfg.pattern_bytes[BYTE_W*i +: BYTE_W] == NEWLINE)) begin
                cfg_has_nl = 1'b1;
            end
        end
    end

    // Compare the window head against the latched pattern, lane by lane.
    always_comb begin
        cmp_len = (r_n < r_live_len) ? r_n : r_live_len;
        same    = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((LEN_W'(i) < cmp_len) && (r_win[i] != r_live_pat[i])) begin
                same = 1'b0;
            end
        end
        pass_byte = (r_live_len == '0) || !same;
        full_hit  = same && (r_live_len != '0) && (r_n >= r_live_len);
    end

    // A new word may enter the pending slot when it is free or can drain.
    assign gen_ok = !r_pend_valid || !i_out_stat.full;

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_win        = r_win;
        n_live_pat   = r_live_pat;
        n_live_len   = r_live_len;
        n_n          = r_n;
        n_ridx       = r_ridx;
        n_end        = r_end;
        n_total      = r_total;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        o_in_pop     = 1'b0;
        gen          = 1'b0;
        gen_byte     = '0;
        fin_push     = 1'b0;
        shift        = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (!i_in_stat.empty) begin
                    o_in_pop = 1'b1;
                    // The pattern is taken up only when no bytes are held.
                    if (r_n == '0) begin
                        for (int i = 0; i < MAX_PATTERN; i++) begin
                            n_live_pat[i] = i_cfg.pattern_bytes[BYTE_W*i +: BYTE_W];
                        end
                        n_live_len = cfg_has_nl ? '0 : cfg_pat_len;
                    end
                    n_win[r_n[IW-1:0]] = i_in_word.in_byte;
                    n_n     = r_n + LEN_W'(1);
                    n_end   = i_in_word.stream_end;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_n == '0) begin
                    n_state = S_FIN;
                end else if (pass_byte) begin
                    gen      = 1'b1;
                    gen_byte = r_win[0];
                    shift    = gen_ok;
                end else if (full_hit) begin
                    if (r_total != '1) begin
                        n_total = r_total + COUNT_W'(1);
                    end
                    n_n    = '0;
                    n_ridx = '0;
                    n_state = (repl_len == '0) ? S_FIN : S_REPL;
                end else begin
                    // Partial match: the remaining bytes stay held.
                    n_state = r_end ? S_FLUSH : S_FIN;
                end
            end
            S_REPL: begin
                gen      = 1'b1;
                gen_byte = i_cfg.replacement_bytes[BYTE_W*r_ridx[RW-1:0] +: BYTE_W];
                if (gen_ok) begin
                    n_ridx = r_ridx + LEN_W'(1);
                    if (r_ridx + LEN_W'(1) == repl_len) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FLUSH: begin
                if (r_n == '0) begin
                    n_state = S_FIN;
                end else begin
                    gen      = 1'b1;
                    gen_byte = r_win[0];
                    shift    = gen_ok;
                end
            end
            S_FIN: begin
                if (r_pend_valid || r_end) begin
                    if (!i_out_stat.full) begin
                        fin_push     = 1'b1;
                        n_pend_valid = 1'b0;
                        if (r_end) begin
                            n_total = '0;
                        end
                        n_state = S_LOAD;
                    end
                end else begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // Drop the head byte of the window.
        if (shift) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                n_win[i] = r_win[i + 1];
            end
            n_n = r_n - LEN_W'(1);
        end

        // The newest word waits in the pending slot until its successor is known.
        if (gen && gen_ok) begin
            n_pend.out_byte      = gen_byte;
            n_pend.byte_valid    = 1'b1;
            n_pend.run_last      = 1'b0;
            n_pend.end_of_output = 1'b0;
            n_pend.replace_count = r_total;
            n_pend_valid         = 1'b1;
        end
    end

    // Closing word: the pending word marked last, or an empty end marker.
    always_comb begin
        if (r_pend_valid) begin
            fin_res               = r_pend;
            fin_res.run_last      = 1'b1;
            fin_res.end_of_output = r_end;
        end else begin
            fin_res.out_byte      = '0;
            fin_res.byte_valid    = 1'b0;
            fin_res.run_last      = 1'b1;
            fin_res.end_of_output = 1'b1;
            fin_res.replace_count = r_total;
        end
    end

    assign o_res_push = fin_push || (gen && gen_ok && r_pend_valid);
    assign o_res      = fin_push ? fin_res : r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_live_len   <= '0;
            r_n          <= '0;
            r_ridx       <= '0;
            r_end        <= 1'b0;
            r_total      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_live_len   <= n_live_len;
            r_n          <= n_n;
            r_ridx       <= n_ridx;
            r_end        <= n_end;
            r_total      <= n_total;
            r_pend_valid <= n_pend_valid;
        end
    end

    // Data registers need no reset.
    always_ff @(posedge i_clk) begin
        r_win      <= n_win;
        r_live_pat <= n_live_pat;
        r_pend     <= n_pend;
    end

`ifndef NO_ASSERTIONS
    // The window never holds more bytes than the pattern can have.
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= LEN_W'(MAX_PATTERN))
        else $error("window count exceeds pattern size");

    // A new item never starts while a word of the previous one is pending.
    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !r_pend_valid)
        else $error("pending word left over at item start");

    // Words are pushed only into a queue with room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_out_stat.full)
        else $error("result pushed into a full queue");

    // Closing a stream clears the replacement count.
    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_end && !i_out_stat.full) |=> (r_total == '0))
        else $error("replacement count not cleared at stream end");

    // Replacement bytes go out only after the matched bytes left the window.
    a_repl_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPL) |-> (r_n == '0))
        else $error("window not empty during replacement");
`endif

endmodule

`default_nettype wire

// ===== rtl/stream_pattern_replace_core.sv =====
// Top level: configuration registers, input queue, engine and result queue.
// Each result word of an item waits in a holding slot before it reaches the result queue and
// the result ports. An item passes through the load, scan and finish states; words that carry
// a text byte are emitted from the scan, replace or flush state, and held bytes are flushed at
// stream end. A full result queue stalls the engine, which emits at most one word per cycle.
// Reset: synchronous, active low; clears queues, window count, count and configuration.
`default_nettype none

module stream_pattern_replace_core
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Input side.
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [BYTE_W-1:0]     i_in_byte,
    input  wire logic                  i_stream_end,
    // Result side.
    output logic                       empty,
    input  wire logic                  pop,
    output logic      [BYTE_W-1:0]     o_out_byte,
    output logic                       o_byte_valid,
    output logic                       o_run_last,
    output logic                       o_end_of_output,
    output logic      [COUNT_W-1:0]    o_replace_count
);

    t_cfg     r_cfg;
    t_in_word in_word;
    t_in_word eng_in_word;
    t_qstat   in_stat;
    t_qstat   out_stat;
    logic     in_pop;
    logic     res_push;
    t_result  res_word;
    t_result  out_word;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_PATTERN_BYTES:      r_cfg.pattern_bytes      <= i_cfg_wdata;
                CFG_PATTERN_LENGTH:     r_cfg.pattern_length     <= i_cfg_wdata[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  r_cfg.replacement_bytes  <= i_cfg_wdata;
                CFG_REPLACEMENT_LENGTH: r_cfg.replacement_length <= i_cfg_wdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input queue.
    assign in_word.in_byte    = i_in_byte;
    assign in_word.stream_end = i_stream_end;
    assign full               = in_stat.full;

    spr_fifo #(
        .WIDTH ($bits(t_in_word)),
        .DEPTH (QUEUE_DEPTH)
    ) u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (in_word),
        .i_pop   (in_pop),
        .o_data  (eng_in_word),
        .o_stat  (in_stat)
    );

    // Matching engine.
    spr_engine #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_stat  (in_stat),
        .i_in_word  (eng_in_word),
        .o_in_pop   (in_pop),
        .i_out_stat (out_stat),
        .o_res_push (res_push),
        .o_res      (res_word)
    );

    // Result queue.
    spr_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_word),
        .i_pop   (pop),
        .o_data  (out_word),
        .o_stat  (out_stat)
    );

    assign empty           = out_stat.empty;
    assign o_out_byte      = out_word.out_byte;
    assign o_byte_valid    = out_word.byte_valid;
    assign o_run_last      = out_word.run_last;
    assign o_end_of_output = out_word.end_of_output;
    assign o_replace_count = out_word.replace_count;

endmodule

`default_nettype wire

// ===== tb/sv/tb_stream_pattern_replace_core.sv =====
// Testbench of the stream pattern replace core: a predicting scoreboard under random stalls.
module tb_stream_pattern_replace_core;
    import spr_pkg::*;

    // Scoreboard: predicts the output words of each accepted text byte and checks the outputs.
    class replace_scoreboard;
        logic [CFG_DATA_W-1:0] pattern_reg;
        logic [LEN_W-1:0]      pattern_len_reg;
        logic [CFG_DATA_W-1:0] replacement_reg;
        logic [LEN_W-1:0]      replacement_len_reg;
        logic [BYTE_W-1:0]     held_bytes [8];
        int                    held_n;
        logic [COUNT_W-1:0]    found_total;
        logic [BYTE_W-1:0]     live_pattern [8];
        int                    live_n;
        t_result               step_words [$];
        t_result               expected_words [$];
        int                    mismatches;
        int                    words_checked;
        int                    bytes_noted;
        int                    streams_closed;
        int                    replacements;

        function new();
            pattern_reg         = '0;
            pattern_len_reg     = '0;
            replacement_reg     = '0;
            replacement_len_reg = '0;
            held_n              = 0;
            found_total         = '0;
            live_n              = 0;
            mismatches          = 0;
            words_checked       = 0;
            bytes_noted         = 0;
            streams_closed      = 0;
            replacements        = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PATTERN_BYTES:      pattern_reg = value;
                CFG_PATTERN_LENGTH:     pattern_len_reg = value[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  replacement_reg = value;
                CFG_REPLACEMENT_LENGTH: replacement_len_reg = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Take a fresh copy of the pattern; a newline anywhere in it disables matching.
        function void latch_pattern();
            live_n = (pattern_len_reg > 8) ? 8 : int'(pattern_len_reg);
            for (int i = 0; i < 8; i++) begin
                live_pattern[i] = pattern_reg[8*i +: 8];
            end
            for (int i = 0; i < 8; i++) begin
                if (i < live_n && live_pattern[i] == NEWLINE) begin
                    live_n = 0;
                end
            end
        endfunction

        function void emit(logic [BYTE_W-1:0] b, logic valid);
            t_result w;
            w.out_byte      = valid ? b : '0;
            w.byte_valid    = valid;
            w.run_last      = 1'b0;
            w.end_of_output = 1'b0;
            w.replace_count = found_total;
            step_words.push_back(w);
        endfunction

        // Predict the output words caused by one accepted text byte.
        function void note_text_byte(logic [BYTE_W-1:0] b, logic last);
            logic [BYTE_W-1:0] win [9];
            int n;
            int pos;
            int m;
            int rlen;
            bit same;
            bit waiting;
            step_words.delete();
            bytes_noted++;
            if (held_n == 0) begin
                latch_pattern();
            end
            n = held_n;
            for (int i = 0; i < n; i++) begin
                win[i] = held_bytes[i];
            end
            win[n] = b;
            n++;
            rlen = (replacement_len_reg > 8) ? 8 : int'(replacement_len_reg);

            // Scan the window: pass bytes that cannot start a match, replace full matches,
            // and stop at a partial match that needs more bytes.
            pos = 0;
            waiting = 1'b0;
            while (pos < n && !waiting) begin
                if (live_n == 0) begin
                    emit(win[pos], 1'b1);
                    pos++;
                end else begin
                    m = (n - pos < live_n) ? n - pos : live_n;
                    same = 1'b1;
                    for (int i = 0; i < m; i++) begin
                        if (win[pos + i] != live_pattern[i]) begin
                            same = 1'b0;
                        end
                    end
                    if (!same) begin
                        emit(win[pos], 1'b1);
                        pos++;
                    end else if (m == live_n) begin
                        if (found_total != '1) begin
                            found_total++;
                        end
                        replacements++;
                        for (int i = 0; i < rlen; i++) begin
                            emit(replacement_reg[8*i +: 8], 1'b1);
                        end
                        pos += live_n;
                    end else begin
                        waiting = 1'b1;
                    end
                end
            end
            held_n = n - pos;
            for (int i = 0; i < held_n; i++) begin
                held_bytes[i] = win[pos + i];
            end

            // The end of a stream flushes the held bytes and restarts the count.
            if (last) begin
                for (int i = 0; i < held_n; i++) begin
                    emit(held_bytes[i], 1'b1);
                end
                held_n = 0;
                if (step_words.size() == 0) begin
                    emit('0, 1'b0);
                end
                step_words[step_words.size() - 1].end_of_output = 1'b1;
                found_total = '0;
                streams_closed++;
            end
            if (step_words.size() > 0) begin
                step_words[step_words.size() - 1].run_last = 1'b1;
            end
            foreach (step_words[i]) begin
                expected_words.push_back(step_words[i]);
            end
        endfunction

        // Compare one accepted output word with the oldest prediction.
        function void check_output_word(logic [BYTE_W-1:0] ob, logic bv, logic rl, logic eo,
                                         logic [COUNT_W-1:0] rc);
            t_result want;
            words_checked++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected output word: byte %h valid %b last %b end %b count %0d",
                             ob, bv, rl, eo, rc);
                end
                return;
            end
            want = expected_words.pop_front();
            if (ob !== want.out_byte || bv !== want.byte_valid || rl !== want.run_last ||
                    eo !== want.end_of_output || rc !== want.replace_count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("word %0d expected: byte %h valid %b last %b end %b count %0d",
                             words_checked, want.out_byte, want.byte_valid, want.run_last,
                             want.end_of_output, want.replace_count);
                    $display("word %0d actual:   byte %h valid %b last %b end %b count %0d",
                             words_checked, ob, bv, rl, eo, rc);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [BYTE_W-1:0]     i_in_byte = '0;
    logic                  i_stream_end = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_byte_valid;
    logic                  o_run_last;
    logic                  o_end_of_output;
    logic [COUNT_W-1:0]    o_replace_count;

    replace_scoreboard sb = new();

    // Text generation state.
    logic [BYTE_W-1:0]     text_q [$];
    logic [CFG_DATA_W-1:0] gen_pattern = '0;
    int                    gen_len = 0;
    int                    settings_used = 0;
    int                    in_run_left = 0;
    bit                    in_calm = 1'b0;
    int                    out_run_left = 0;
    bit                    out_calm = 1'b0;

    stream_pattern_replace_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_stream_end    (i_stream_end),
        .empty           (empty),
        .pop             (pop),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_run_last      (o_run_last),
        .o_end_of_output (o_end_of_output),
        .o_replace_count (o_replace_count)
    );

    always #4 i_clk = ~i_clk;

    // Watch both handshakes on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            sb.note_text_byte(i_in_byte, i_stream_end);
        end
        if (i_rst_n && pop && !empty) begin
            sb.check_output_word(o_out_byte, o_byte_valid, o_run_last, o_end_of_output,
                                 o_replace_count);
        end
    end

    // Write one register; the write enable stays high for a following write.
    task automatic put_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        sb.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic load_config(logic [CFG_DATA_W-1:0] pb, logic [LEN_W-1:0] pl,
                               logic [CFG_DATA_W-1:0] rb, logic [LEN_W-1:0] rl);
        put_reg(CFG_PATTERN_BYTES, pb);
        put_reg(CFG_PATTERN_LENGTH, {{(CFG_DATA_W-LEN_W){1'b0}}, pl});
        put_reg(CFG_REPLACEMENT_BYTES, rb);
        put_reg(CFG_REPLACEMENT_LENGTH, {{(CFG_DATA_W-LEN_W){1'b0}}, rl});
        i_cfg_we <= 1'b0;
        gen_pattern = pb;
        gen_len = (pl > 8) ? 8 : int'(pl);
        settings_used++;
    endtask

    // Wait until every predicted word has arrived, then let the engine go quiet.
    task automatic settle();
        push <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (80) @(posedge i_clk);
    endtask

    // Offer one word after a random gap and hold it until it is taken.
    task automatic send_word(logic [BYTE_W-1:0] b, logic last);
        int gap;
        if (in_run_left == 0) begin
            in_calm = ($urandom_range(0, 3) == 0);
            in_run_left = $urandom_range(8, 40);
        end
        in_run_left--;
        gap = in_calm ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_in_byte    <= b;
        i_stream_end <= last;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_text(bit close);
        foreach (text_q[i]) begin
            send_word(text_q[i], close && (i == text_q.size() - 1));
        end
    endtask

    // Build text rich in whole and broken copies of the pattern, with newlines and noise.
    task automatic build_text(int len);
        int r;
        int cut;
        text_q.delete();
        while (text_q.size() < len) begin
            r = $urandom_range(0, 9);
            if (r <= 3 && gen_len != 0) begin
                for (int i = 0; i < gen_len; i++) begin
                    text_q.push_back(gen_pattern[8*i +: 8]);
                end
            end else if (r <= 5 && gen_len > 1) begin
                cut = $urandom_range(1, gen_len - 1);
                for (int i = 0; i < cut; i++) begin
                    text_q.push_back(gen_pattern[8*i +: 8]);
                end
            end else if (r == 6) begin
                text_q.push_back(NEWLINE);
            end else if (r == 7) begin
                text_q.push_back(BYTE_W'($urandom_range(0, 255)));
            end else if (gen_len != 0 && r == 8) begin
                text_q.push_back(gen_pattern[8*$urandom_range(0, gen_len - 1) +: 8]);
            end else begin
                text_q.push_back(8'h61 + BYTE_W'($urandom_range(0, 3)));
            end
        end
    endtask

    // Draw a register setting; lengths include zero and values past the maximum.
    task automatic pick_config();
        logic [CFG_DATA_W-1:0] pb;
        logic [CFG_DATA_W-1:0] rb;
        logic [LEN_W-1:0]      pl;
        logic [LEN_W-1:0]      rl;
        int                    sel;
        sel = $urandom_range(0, 9);
        pl = (sel == 0) ? 4'd0 : (sel == 1) ? LEN_W'($urandom_range(9, 15))
                                            : LEN_W'($urandom_range(1, 8));
        for (int i = 0; i < 8; i++) begin
            sel = $urandom_range(0, 23);
            if (sel == 0) begin
                pb[8*i +: 8] = NEWLINE;
            end else if (sel <= 3) begin
                pb[8*i +: 8] = BYTE_W'($urandom_range(0, 255));
            end else begin
                pb[8*i +: 8] = 8'h61 + BYTE_W'($urandom_range(0, 3));
            end
        end
        if ($urandom_range(0, 15) == 0) begin
            pb = '1;
        end
        sel = $urandom_range(0, 9);
        rl = (sel == 0) ? 4'd0 : (sel == 1) ? LEN_W'($urandom_range(9, 15))
                                            : LEN_W'($urandom_range(1, 8));
        sel = $urandom_range(0, 9);
        rb = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
        load_config(pb, pl, rb, rl);
    endtask

    // Output side: pop after a random stall, with stretches of no stall.
    initial begin
        int stall;
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (out_run_left == 0) begin
                out_calm = ($urandom_range(0, 3) == 0);
                out_run_left = $urandom_range(8, 40);
            end
            out_run_left--;
            stall = out_calm ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) begin
                @(posedge i_clk);
            end
        end
    end

    // Main sequence: reset, directed cases, random settings, then the final check.
    initial begin
        int random_bytes;
        int nstreams;
        bit close;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset leaves the pattern empty, so every byte passes through.
        text_q = '{8'h00, 8'hFF, NEWLINE};
        send_text(1'b1);
        settle();

        // Overlapping candidates, two matches, and a held byte flushed at the end.
        load_config(64'h6261, 4'd2, 64'h5A5958, 4'd3);
        text_q = '{8'h61, 8'h62, 8'h61, 8'h61, 8'h62, 8'h78, 8'h61};
        send_text(1'b1);
        settle();

        // Deleting the match on the final byte leaves a word with no text byte.
        load_config(64'h6261, 4'd2, '1, 4'd0);
        text_q = '{8'h61, 8'h62};
        send_text(1'b1);
        settle();

        // Lengths past the maximum are clamped to eight bytes.
        load_config(64'h4847_4645_4443_4241, 4'd15, '1, 4'd15);
        text_q = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48};
        send_text(1'b1);
        settle();

        // A pattern holding a newline never matches.
        load_config(64'h0A61, 4'd2, 64'h21, 4'd1);
        text_q = '{8'h61, NEWLINE, 8'h61};
        send_text(1'b1);
        settle();

        // The pattern changes while a byte is held: the old pattern stays in force,
        // the new replacement is used.
        load_config(64'h6261, 4'd2, 64'h2B, 4'd1);
        text_q = '{8'h61};
        send_text(1'b0);
        settle();
        load_config(64'h6463, 4'd2, 64'h3D3D, 4'd2);
        text_q = '{8'h62};
        send_text(1'b1);
        settle();

        // Random settings, each with a few streams; some are left open across a change.
        random_bytes = 0;
        while (random_bytes < 420) begin
            pick_config();
            nstreams = $urandom_range(1, 3);
            for (int s = 0; s < nstreams; s++) begin
                build_text(($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 24));
                close = (s < nstreams - 1) || ($urandom_range(0, 3) != 0);
                send_text(close);
                random_bytes += text_q.size();
            end
            settle();
        end

        // Close whatever stream is still open.
        text_q = '{8'h2E};
        send_text(1'b1);
        settle();

        $display("Sent %0d text bytes under %0d register settings, closing %0d streams.",
                 sb.bytes_noted, settings_used, sb.streams_closed);
        $display("Checked %0d output words covering %0d predicted replacements.",
                 sb.words_checked, sb.replacements);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard limit on the run time.
    initial begin
        #8000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
